// ===== rtl/hfsc_pkg.sv =====
package hfsc_pkg;

  localparam int MAX_SIG_BYTES = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int OFS_W = 32;

  localparam logic [63:0] RST_HDR_PATTERN = 64'd16767231;
  localparam logic [3:0] RST_HDR_LENGTH = 4'd3;
  localparam logic [63:0] RST_FTR_PATTERN = 64'd55807;
  localparam logic [3:0] RST_FTR_LENGTH = 4'd2;
  localparam logic [OFS_W-1:0] RST_BASE_OFFSET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HDR_PATTERN = 3'd0,
    REG_HDR_LENGTH = 3'd1,
    REG_FTR_PATTERN = 3'd2,
    REG_FTR_LENGTH = 3'd3,
    REG_BASE_OFFSET = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_PENDING = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef struct packed {
    logic [OFS_W-1:0] region_end;
    logic [OFS_W-1:0] region_start;
    status_t status;
  } res_t;

endpackage

// ===== rtl/header_footer_signature_carver.sv =====
// Channel   Dir  Words                         Fields (low bit first)
// s_*       in   one source byte per word      tdata: data_byte; tlast: final_byte
// m_*       out  zero or one result per byte  tdata: region_start, region_end; tuser: status
// cfg_*     in   register write                index 0..4, data up to 64 bits
//
// One byte per cycle sustained while m_tready stays high; an accepted byte is held in the
// input register and its result in the result register. The window compares for all footer
// ages run in parallel, combinationally, between the input register and the result register.
// Reset (rst, synchronous) loads the register defaults and clears the window.
// A stalled result holds the result register; the input register then holds one
// more byte and tready drops until the result is taken.
module header_footer_signature_carver #(
  parameter int MAX_SIGNATURE_BYTES = hfsc_pkg::MAX_SIG_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,                       // data_byte
  input  logic s_tlast,                             // final_byte
  output logic m_tvalid,
  input  logic m_tready,
  output logic [2*hfsc_pkg::OFS_W-1:0] m_tdata,     // region_start, region_end
  output logic [1:0] m_tuser,                       // status
  input  logic cfg_we,
  input  logic [hfsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfsc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hfsc_pkg::*;

  localparam int M = MAX_SIGNATURE_BYTES;
  localparam int W = 8 * M;
  localparam int LW = $clog2(M + 1);

  logic in_valid;
  logic [7:0] in_byte;
  logic in_last;
  logic advance;
  logic fire;

  logic [W-1:0] hdr_apat;
  logic [M-1:0] hdr_mask;
  logic [LW-1:0] hdr_len;
  logic [W-1:0] ftr_apat;
  logic [M-1:0] ftr_mask;
  logic [LW-1:0] ftr_len;
  logic [OFS_W-1:0] base_offset;
  logic base_load;

  logic res_valid;
  res_t res;
  res_t out_res;

  assign advance = !m_tvalid || m_tready;
  assign fire = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hfsc_cfg #(.MAX_SIGNATURE_BYTES(M)) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .hdr_apat(hdr_apat),
    .hdr_mask(hdr_mask),
    .hdr_len(hdr_len),
    .ftr_apat(ftr_apat),
    .ftr_mask(ftr_mask),
    .ftr_len(ftr_len),
    .base_offset(base_offset),
    .base_load(base_load)
  );

  hfsc_scan #(.MAX_SIGNATURE_BYTES(M)) u_scan (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .data_byte(in_byte),
    .final_byte(in_last),
    .hdr_apat(hdr_apat),
    .hdr_mask(hdr_mask),
    .hdr_len(hdr_len),
    .ftr_apat(ftr_apat),
    .ftr_mask(ftr_mask),
    .ftr_len(ftr_len),
    .base_offset(base_offset),
    .base_load(base_load),
    .res_valid(res_valid),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.region_end, out_res.region_start};
  assign m_tuser = out_res.status;

  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !fire)
    else $error("scan advanced while result stalled");

  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid)
    else $error("input stalled with empty input register");

  assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid) |=> m_tvalid)
    else $error("result dropped");

endmodule

// ===== rtl/hfsc_cfg.sv =====
module hfsc_cfg #(
  parameter int MAX_SIGNATURE_BYTES = hfsc_pkg::MAX_SIG_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [hfsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [8*MAX_SIGNATURE_BYTES-1:0] hdr_apat,
  output logic [MAX_SIGNATURE_BYTES-1:0] hdr_mask,
  output logic [$clog2(MAX_SIGNATURE_BYTES+1)-1:0] hdr_len,
  output logic [8*MAX_SIGNATURE_BYTES-1:0] ftr_apat,
  output logic [MAX_SIGNATURE_BYTES-1:0] ftr_mask,
  output logic [$clog2(MAX_SIGNATURE_BYTES+1)-1:0] ftr_len,
  output logic [hfsc_pkg::OFS_W-1:0] base_offset,
  output logic base_load
);
  import hfsc_pkg::*;

  localparam int M = MAX_SIGNATURE_BYTES;
  localparam int W = 8 * M;
  localparam int LW = $clog2(M + 1);

  logic [W-1:0] hdr_pattern;
  logic [3:0] hdr_length;
  logic [W-1:0] ftr_pattern;
  logic [3:0] ftr_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pattern <= RST_HDR_PATTERN[W-1:0];
      hdr_length <= RST_HDR_LENGTH;
      ftr_pattern <= RST_FTR_PATTERN[W-1:0];
      ftr_length <= RST_FTR_LENGTH;
      base_offset <= RST_BASE_OFFSET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_HDR_PATTERN: hdr_pattern <= cfg_data[W-1:0];
        REG_HDR_LENGTH: hdr_length <= cfg_data[3:0];
        REG_FTR_PATTERN: ftr_pattern <= cfg_data[W-1:0];
        REG_FTR_LENGTH: ftr_length <= cfg_data[3:0];
        REG_BASE_OFFSET: base_offset <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // reload position in the cycle after the write, from the updated register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_load <= 1'b0;
    end else begin
      base_load <= cfg_we && (cfg_reg_t'(cfg_index) == REG_BASE_OFFSET);
    end
  end

  function automatic logic [LW-1:0] eff_len(input logic [3:0] len);
    logic [LW-1:0] r;
    if (len == 4'd0) begin
      r = LW'(1);
    end else if (int'(len) > M) begin
      r = LW'(M);
    end else begin
      r = LW'(len);
    end
    return r;
  endfunction

  // align so byte j of the result pairs with window age j (newest first)
  function automatic logic [W-1:0] align(input logic [W-1:0] pat, input logic [LW-1:0] len);
    logic [W-1:0] r;
    r = '0;
    for (int j = 0; j < M; j++) begin
      for (int k = 0; k < M; k++) begin
        if (int'(len) - 1 - j == k) begin
          r[8*j +: 8] = pat[8*k +: 8];
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    hdr_len = eff_len(hdr_length);
    ftr_len = eff_len(ftr_length);
    hdr_apat = align(hdr_pattern, hdr_len);
    ftr_apat = align(ftr_pattern, ftr_len);
    for (int j = 0; j < M; j++) begin
      hdr_mask[j] = j < int'(hdr_len);
      ftr_mask[j] = j < int'(ftr_len);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    hdr_len != '0 && ftr_len != '0 && int'(hdr_len) <= M && int'(ftr_len) <= M)
    else $error("effective signature length out of range");

  assert property (@(posedge clk) disable iff (rst)
    hdr_mask[0] && ftr_mask[0])
    else $error("signature mask lost its first byte");

  assert property (@(posedge clk) disable iff (rst)
    $countones(hdr_mask) == int'(hdr_len))
    else $error("header mask disagrees with length");

endmodule

// ===== rtl/hfsc_scan.sv =====
module hfsc_scan #(
  parameter int MAX_SIGNATURE_BYTES = hfsc_pkg::MAX_SIG_BYTES
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  logic [7:0] data_byte,
  input  logic final_byte,
  input  logic [8*MAX_SIGNATURE_BYTES-1:0] hdr_apat,
  input  logic [MAX_SIGNATURE_BYTES-1:0] hdr_mask,
  input  logic [$clog2(MAX_SIGNATURE_BYTES+1)-1:0] hdr_len,
  input  logic [8*MAX_SIGNATURE_BYTES-1:0] ftr_apat,
  input  logic [MAX_SIGNATURE_BYTES-1:0] ftr_mask,
  input  logic [$clog2(MAX_SIGNATURE_BYTES+1)-1:0] ftr_len,
  input  logic [hfsc_pkg::OFS_W-1:0] base_offset,
  input  logic base_load,
  output logic res_valid,
  output hfsc_pkg::res_t res
);
  import hfsc_pkg::*;

  localparam int M = MAX_SIGNATURE_BYTES;
  localparam int W = 8 * M;
  localparam int LW = $clog2(M + 1);

  logic [W-1:0] recent;
  logic [LW-1:0] seen;
  logic [OFS_W-1:0] position;
  logic in_region;
  logic [OFS_W-1:0] header_start;

  logic [W-1:0] recent_next;
  logic [LW-1:0] seen_next;
  logic [OFS_W-1:0] position_next;
  logic in_region_next;
  logic [OFS_W-1:0] header_start_next;

  logic [W-1:0] win;
  logic [LW-1:0] seen_inc;
  logic hdr_hit;
  logic [M-1:0] ftr_eq;
  logic ftr_in_hdr;
  logic [OFS_W-1:0] ftr_age;
  logic found;
  logic [OFS_W-1:0] end_off;

  always_comb begin
    win = (recent << 8) | W'(data_byte);
    seen_inc = (seen == LW'(M)) ? seen : seen + LW'(1);

    hdr_hit = hdr_len <= seen_inc;
    for (int j = 0; j < M; j++) begin
      if (hdr_mask[j] && win[8*j +: 8] != hdr_apat[8*j +: 8]) begin
        hdr_hit = 1'b0;
      end
    end

    for (int e = 0; e < M; e++) begin
      ftr_eq[e] = 1'b1;
      for (int j = 0; j < M - e; j++) begin
        if (ftr_mask[j] && win[8*(e+j) +: 8] != ftr_apat[8*j +: 8]) begin
          ftr_eq[e] = 1'b0;
        end
      end
    end

    // oldest footer end inside the header wins
    ftr_in_hdr = 1'b0;
    ftr_age = '0;
    for (int e = 0; e < M; e++) begin
      if (ftr_eq[e] && e + int'(ftr_len) <= int'(hdr_len)) begin
        ftr_in_hdr = 1'b1;
        ftr_age = OFS_W'(e);
      end
    end

    recent_next = win;
    seen_next = seen_inc;
    in_region_next = in_region;
    header_start_next = header_start;
    position_next = position + OFS_W'(1);
    found = 1'b0;
    end_off = '0;

    if (!in_region) begin
      if (hdr_hit) begin
        in_region_next = 1'b1;
        header_start_next = position - (OFS_W'(hdr_len) - OFS_W'(1));
        seen_next = hdr_len;
        if (ftr_in_hdr) begin
          found = 1'b1;
          end_off = position - ftr_age + OFS_W'(1);
        end
      end
    end else if (ftr_eq[0] && ftr_len <= seen_inc) begin
      found = 1'b1;
      end_off = position + OFS_W'(1);
    end

    res_valid = found || final_byte;
    res.region_start = header_start_next;
    res.region_end = end_off;
    res.status = ST_FOUND;
    if (found) begin
      in_region_next = 1'b0;
      seen_next = '0;
    end else begin
      res.region_start = '0;
      res.status = in_region_next ? ST_PENDING : ST_NONE;
    end

    if (final_byte) begin
      recent_next = '0;
      seen_next = '0;
      in_region_next = 1'b0;
      header_start_next = '0;
      position_next = base_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent <= '0;
      seen <= '0;
      position <= RST_BASE_OFFSET;
      in_region <= 1'b0;
      header_start <= '0;
    end else if (base_load) begin
      position <= base_offset;
    end else if (fire) begin
      recent <= recent_next;
      seen <= seen_next;
      position <= position_next;
      in_region <= in_region_next;
      header_start <= header_start_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    int'(seen) <= M)
    else $error("byte count beyond window depth");

  assert property (@(posedge clk) disable iff (rst)
    (fire && !base_load && res_valid && res.status == ST_FOUND) |=> !in_region && seen == '0)
    else $error("region found but search not restarted");

  assert property (@(posedge clk) disable iff (rst)
    (fire && !base_load && final_byte) |=> !in_region && seen == '0 && recent == '0)
    else $error("stream state not cleared after final word");

  assert property (@(posedge clk) disable iff (rst)
    (fire && !base_load && !in_region && hdr_hit && !ftr_in_hdr) |=> in_region || $past(final_byte))
    else $error("header match did not open a region");

endmodule

// ===== tb/header_footer_signature_carver_test.sv =====
`timescale 1ns / 1ps

module header_footer_signature_carver_test;
  import hfsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam int READY_ALWAYS = 0;
  localparam int READY_PATTERN = 1;
  localparam int READY_RANDOM = 2;
  localparam int PHASES = 14;
  localparam int HALF_PHASE_BYTES = 45;

  typedef struct {
    logic [7:0] data;
    logic last;
  } src_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2*OFS_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  header_footer_signature_carver dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // carver mirror: registers and scan state
  logic [63:0] hdr_pat = RST_HDR_PATTERN;
  logic [3:0] hdr_len = RST_HDR_LENGTH;
  logic [63:0] ftr_pat = RST_FTR_PATTERN;
  logic [3:0] ftr_len = RST_FTR_LENGTH;
  logic [OFS_W-1:0] base_ofs = RST_BASE_OFFSET;
  logic [63:0] window = '0;
  int fill = 0;
  logic [OFS_W-1:0] next_ofs = RST_BASE_OFFSET;
  bit pending = 0;
  logic [OFS_W-1:0] hdr_ofs = '0;

  res_t expected_regions[$];
  src_word_t byte_q[$];
  src_word_t driver_word;
  res_t want;

  int words_queued = 0;
  int words_accepted = 0;
  int mismatches = 0;
  int found_count = 0;
  int open_count = 0;
  int none_count = 0;
  int settings_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = READY_ALWAYS;
  int stall_left = 0;
  logic [15:0] stall_pattern = '1;
  logic [3:0] cycle_ct = '0;

  function automatic int eff_len(logic [3:0] len);
    if (len == 0) return 1;
    if (len > MAX_SIG_BYTES) return MAX_SIG_BYTES;
    return len;
  endfunction

  // signature ending at window age 'age' (0 = newest byte)
  function automatic bit match_at(logic [63:0] pat, int len, int age);
    int k;
    int a;
    if (age + len > fill) return 0;
    for (k = 0; k < len; k++) begin
      a = age + len - 1 - k;
      if (window[8*a +: 8] != pat[8*k +: 8]) return 0;
    end
    return 1;
  endfunction

  task automatic carve_byte(input logic [7:0] b, input logic fin);
    int hl;
    int fl;
    int e;
    logic [OFS_W-1:0] here;
    logic [OFS_W-1:0] end_ofs;
    bit hit;
    res_t r;
    hl = eff_len(hdr_len);
    fl = eff_len(ftr_len);
    here = next_ofs;
    hit = 0;
    end_ofs = '0;
    window = {window[55:0], b};
    if (fill < MAX_SIG_BYTES) fill++;
    if (!pending) begin
      if (match_at(hdr_pat, hl, 0)) begin
        pending = 1;
        hdr_ofs = here - OFS_W'(hl - 1);
        fill = hl;
        // oldest footer end inside the header wins
        for (e = MAX_SIG_BYTES - 1; e >= 0 && !hit; e--) begin
          if (match_at(ftr_pat, fl, e)) begin
            hit = 1;
            end_ofs = here - OFS_W'(e) + 1;
          end
        end
      end
    end else if (match_at(ftr_pat, fl, 0)) begin
      hit = 1;
      end_ofs = here + 1;
    end
    next_ofs = here + 1;
    if (hit) begin
      r.region_start = hdr_ofs;
      r.region_end = end_ofs;
      r.status = ST_FOUND;
      expected_regions.push_back(r);
      pending = 0;
      fill = 0;
    end else if (fin) begin
      r.region_start = '0;
      r.region_end = '0;
      r.status = pending ? ST_PENDING : ST_NONE;
      expected_regions.push_back(r);
    end
    if (fin) begin
      window = '0;
      fill = 0;
      pending = 0;
      hdr_ofs = '0;
      next_ofs = base_ofs;
    end
  endtask

  // source side: bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        carve_byte(s_tdata, s_tlast);
        words_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || byte_q.size() == 0) begin
          s_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          driver_word = byte_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= driver_word.data;
          s_tlast <= driver_word.last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 47);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // result side: check and stall
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      cycle_ct <= cycle_ct + 1;
      if (m_tvalid && m_tready) begin
        if (expected_regions.size() == 0) begin
          $error("unexpected result: region_start %h region_end %h status %0d",
                 m_tdata[OFS_W-1:0], m_tdata[2*OFS_W-1:OFS_W], m_tuser);
          mismatches++;
        end else begin
          want = expected_regions.pop_front();
          if (m_tdata[OFS_W-1:0] !== want.region_start) begin
            $error("region_start: expected %h actual %h",
                   want.region_start, m_tdata[OFS_W-1:0]);
            mismatches++;
          end
          if (m_tdata[2*OFS_W-1:OFS_W] !== want.region_end) begin
            $error("region_end: expected %h actual %h",
                   want.region_end, m_tdata[2*OFS_W-1:OFS_W]);
            mismatches++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, m_tuser);
            mismatches++;
          end
          case (want.status)
            ST_FOUND: found_count++;
            ST_PENDING: open_count++;
            default: none_count++;
          endcase
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(READY_ALWAYS, READY_RANDOM);
        stall_left = $urandom_range(32, 256);
        stall_pattern = 16'($urandom);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        READY_ALWAYS: m_tready <= 1'b1;
        READY_PATTERN: m_tready <= stall_pattern[cycle_ct];
        default: m_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic fin);
    src_word_t w;
    w.data = b;
    w.last = fin;
    byte_q.push_back(w);
    words_queued++;
  endtask

  task automatic add_pattern(input logic [63:0] pat, input int n);
    int k;
    for (k = 0; k < n; k++) add_byte(pat[8*k +: 8], 1'b0);
  endtask

  // random bytes, often taken from the signatures
  task automatic add_filler(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: add_byte(hdr_pat[8*$urandom_range(0, 7) +: 8], 1'b0);
        1: add_byte(ftr_pat[8*$urandom_range(0, 7) +: 8], 1'b0);
        default: add_byte(8'($urandom), 1'b0);
      endcase
    end
  endtask

  task automatic add_source();
    int regions;
    int r;
    int start_ct;
    src_word_t w;
    start_ct = words_queued;
    if ($urandom_range(0, 4) == 0) begin
      add_filler($urandom_range(1, 24));
    end else begin
      regions = $urandom_range(0, 3);
      for (r = 0; r < regions; r++) begin
        add_filler($urandom_range(0, 10));
        if ($urandom_range(0, 5) == 0)
          add_pattern(hdr_pat, $urandom_range(1, eff_len(hdr_len)));
        add_pattern(hdr_pat, eff_len(hdr_len));
        add_filler($urandom_range(0, 10));
        if ($urandom_range(0, 4) != 0) add_pattern(ftr_pat, eff_len(ftr_len));
      end
      add_filler($urandom_range(0, 4));
    end
    if (words_queued == start_ct) add_filler(1);
    w = byte_q.pop_back();
    w.last = ($urandom_range(0, 9) != 0);
    byte_q.push_back(w);
  endtask

  task automatic wait_idle();
    while (words_accepted != words_queued || expected_regions.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_HDR_PATTERN: hdr_pat = value;
      REG_HDR_LENGTH: hdr_len = value[3:0];
      REG_FTR_PATTERN: ftr_pat = value;
      REG_FTR_LENGTH: ftr_len = value[3:0];
      REG_BASE_OFFSET: begin
        base_ofs = value[OFS_W-1:0];
        next_ofs = base_ofs;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] hp, input logic [3:0] hl,
                            input logic [63:0] fp, input logic [3:0] fl,
                            input logic [OFS_W-1:0] base);
    write_reg(REG_HDR_PATTERN, hp);
    write_reg(REG_HDR_LENGTH, {$urandom, 15'($urandom_range(0, 15'h7fff)), 13'b0, hl});
    write_reg(REG_FTR_PATTERN, fp);
    write_reg(REG_FTR_LENGTH, {$urandom, 28'($urandom), fl});
    write_reg(REG_BASE_OFFSET, {$urandom, base});
    write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), {$urandom, $urandom});
    settings_count++;
  endtask

  initial begin
    int p;
    int k;
    int phase_start;
    logic [63:0] hp;
    logic [63:0] fp;
    logic [3:0] hl;
    logic [3:0] fl;
    logic [OFS_W-1:0] base;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset signatures: header FF D8 FF, footer FF D9
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0); add_byte(8'hD8, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'h12, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hD9, 1'b0);
    add_byte(8'hFF, 1'b0); add_byte(8'hD8, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'h34, 1'b1);
    add_byte(8'hFF, 1'b0); add_byte(8'hD8, 1'b0); add_byte(8'hFF, 1'b0);
    add_byte(8'hFF, 1'b0); add_byte(8'hD9, 1'b1);
    wait_idle();

    // footer inside the header, offsets wrapping past the top
    set_config(64'hFFFF_FFFF_FFEF_CDAB, 4'd3, 64'h0000_0000_0000_00CD, 4'd1,
               32'hFFFF_FFFE);
    add_byte(8'hAB, 1'b0); add_byte(8'hCD, 1'b0); add_byte(8'hEF, 1'b0);
    add_byte(8'h00, 1'b1);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: hl = 4'd0;
        1: hl = 4'd8;
        2: hl = 4'd15;
        default: hl = (p % 4 == 0) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
      endcase
      case (p)
        3: hp = '0;
        4: hp = '1;
        default: hp = {$urandom, $urandom};
      endcase
      if (p % 3 == 0) begin
        k = $urandom_range(0, eff_len(hl) - 1);
        fp = hp >> (8 * k);
        fl = 4'($urandom_range(1, eff_len(hl) - k));
      end else begin
        fp = (p == 4) ? '0 : ((p == 3) ? '1 : {$urandom, $urandom});
        case (p)
          1: fl = 4'd0;
          2: fl = 4'd8;
          5: fl = 4'd12;
          default: fl = 4'($urandom_range(0, 15));
        endcase
      end
      case (p)
        0: base = '0;
        1: base = '1;
        2: base = 32'hFFFF_FFF8;
        default: base = $urandom;
      endcase
      set_config(hp, hl, fp, fl, base);
      phase_start = words_queued;
      while (words_queued - phase_start < HALF_PHASE_BYTES) add_source();
      wait_idle();
      phase_start = words_queued;
      while (words_queued - phase_start < HALF_PHASE_BYTES) add_source();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("scanned %0d bytes under %0d register settings", words_accepted,
             settings_count);
    $display("regions %0d, sources ended with header open %0d, without header %0d",
             found_count, open_count, none_count);
    if (mismatches == 0 && expected_regions.size() == 0) begin
      $display("[header_footer_signature_carver] OK");
    end else begin
      $display("[header_footer_signature_carver] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[header_footer_signature_carver] ERROR");
    $finish;
  end

endmodule
